FILE: src/vlfr_pkg.sv
package vlfr_pkg;

   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned LengthWidth    = 28;
   localparam int unsigned SeenWidth      = 3;
   localparam int unsigned DigitBits      = 7;
   localparam int unsigned ShiftWidth     = 6;
   localparam int unsigned MaxLenBytesDef = 4;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_FRAME_END = 1'b1
   } kind_type;

   // Byte held in the input stage, as seen by the parser.
   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] rx_byte;
   } in_stage_type;

endpackage

FILE: src/vlfr_stream_if.sv
interface vlfr_req_if;
   logic                           valid;
   logic                           ready;
   logic [vlfr_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vlfr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [vlfr_pkg::ByteWidth-1:0]   data_byte;
   logic [vlfr_pkg::ByteWidth-1:0]   frame_type;
   logic [vlfr_pkg::LengthWidth-1:0] frame_length;
   logic                             checksum_ok;

   modport source (output valid, output kind, output data_byte, output frame_type,
                   output frame_length, output checksum_ok, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_type,
                   input frame_length, input checksum_ok, output ready);
endinterface

FILE: src/varint_length_frame_receiver.sv
// Byte-stream deframer with a base-128 length field.
// req_chan carries one received byte per transaction (rx_byte). Frames are:
// start byte, type byte, 1..MAX_LEN_BYTES length bytes (7 bits each, low group
// first, top bit set means more follow), payload bytes, one checksum byte.
// rsp_chan gives one transaction per payload byte (kind 0, data_byte) and one
// at the checksum byte (kind 1, checksum_ok) carrying frame_type and
// frame_length. Start, type and length bytes give no transaction.
// An accepted byte is held in the input register, then parsed; its result is
// registered in the result register, which drives rsp_chan.
// Throughput: one byte per cycle when rsp_chan does not stall, set by the
// state update between the input register and the result register.
// Reset (synchronous) empties both registers and returns the parser to waiting
// for a start byte. When rsp_chan stalls, the result register holds; the input
// register still takes one more byte, then req_chan.ready drops until the
// result is taken. Bytes that produce no result wait while stalled as well;
// they drain only once the result register is empty or being taken.
module varint_length_frame_receiver #(
   parameter int unsigned MAX_LEN_BYTES = vlfr_pkg::MaxLenBytesDef
) (
   input  logic       clock,
   input  logic       reset,
   vlfr_req_if.sink   req_chan,
   vlfr_rsp_if.source rsp_chan
);

   vlfr_pkg::in_stage_type stage;
   logic                   take;

   vlfr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   vlfr_parse #(
      .MAX_LEN_BYTES (MAX_LEN_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: src/vlfr_in_stage.sv
module vlfr_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   vlfr_req_if.sink                    req_chan,
   input  logic                        take,
   output vlfr_pkg::in_stage_type      stage
);

   logic                           valid_ff, valid_in;
   logic [vlfr_pkg::ByteWidth-1:0] byte_ff, byte_in;
   logic                           load;

   // Slot is free when empty or when the parser drains it this cycle.
   assign req_chan.ready = !reset && (!valid_ff || take);
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_chan.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

FILE: src/vlfr_parse.sv
module vlfr_parse #(
   parameter int unsigned MAX_LEN_BYTES = vlfr_pkg::MaxLenBytesDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vlfr_pkg::in_stage_type stage,
   output logic                   take,
   vlfr_rsp_if.source             rsp_chan
);

   localparam int unsigned BW = vlfr_pkg::ByteWidth;
   localparam int unsigned LW = vlfr_pkg::LengthWidth;
   localparam int unsigned SW = vlfr_pkg::SeenWidth;
   localparam logic [SW:0] MaxCount = (SW+1)'(MAX_LEN_BYTES);

   vlfr_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0]       sum_ff, sum_in;
   logic [BW-1:0]       type_ff, type_in;
   logic [LW-1:0]       length_ff, length_in;
   logic [SW-1:0]       seen_ff, seen_in;
   logic [LW-1:0]       left_ff, left_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic [BW-1:0]       out_data_ff, out_data_in;
   logic [BW-1:0]       out_type_ff, out_type_in;
   logic [LW-1:0]       out_len_ff, out_len_in;
   logic                out_ok_ff, out_ok_in;

   logic [BW-1:0]                       b;
   logic [vlfr_pkg::ShiftWidth-1:0]     shamt;
   logic [LW-1:0]                       part;
   logic [SW:0]                         count;
   logic [LW-1:0]                       len_sum;
   logic                                emit;

   assign b     = stage.rx_byte;
   assign take  = stage.valid && (!out_valid_ff || rsp_chan.ready);
   // 7 * seen as shift - subtract, seen is at most 7
   assign shamt = {seen_ff, 3'b000} - {3'b000, seen_ff};
   assign part  = {{(LW-vlfr_pkg::DigitBits){1'b0}}, b[vlfr_pkg::DigitBits-1:0]} << shamt;
   assign len_sum = length_ff + part;
   // count of length bytes including this one, where seen at all ones gives eight
   assign count = (seen_ff == {SW{1'b1}}) ? (SW+1)'(8) : {1'b0, seen_ff} + (SW+1)'(1);

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      left_in   = left_ff;
      emit        = 1'b0;
      out_kind_in = vlfr_pkg::KIND_PAYLOAD;
      out_data_in = '0;
      out_ok_in   = 1'b0;
      if (take) begin
         unique case (phase_ff)
            vlfr_pkg::PH_TYPE: begin
               type_in  = b;
               sum_in   = sum_ff + b;
               phase_in = vlfr_pkg::PH_LENGTH;
            end
            vlfr_pkg::PH_LENGTH: begin
               sum_in    = sum_ff + b;
               length_in = len_sum;
               seen_in   = seen_ff + SW'(1);
               if (!b[BW-1] || count >= MaxCount) begin
                  left_in  = len_sum;
                  phase_in = (len_sum != '0) ? vlfr_pkg::PH_PAYLOAD : vlfr_pkg::PH_CHECK;
               end
            end
            vlfr_pkg::PH_PAYLOAD: begin
               left_in = left_ff - LW'(1);
               if (left_ff == LW'(1)) begin
                  phase_in = vlfr_pkg::PH_CHECK;
               end
               emit        = 1'b1;
               out_data_in = b;
            end
            vlfr_pkg::PH_CHECK: begin
               emit        = 1'b1;
               out_kind_in = vlfr_pkg::KIND_FRAME_END;
               out_ok_in   = ((BW'(0) - sum_ff) == b);
               phase_in    = vlfr_pkg::PH_START;
            end
            default: begin
               sum_in    = b;
               type_in   = '0;
               length_in = '0;
               seen_in   = '0;
               left_in   = '0;
               phase_in  = vlfr_pkg::PH_TYPE;
            end
         endcase
      end
      // result fields report the frame state after this byte
      out_type_in = type_in;
      out_len_in  = length_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= vlfr_pkg::PH_START;
         sum_ff       <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         seen_ff      <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         seen_ff      <= seen_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
      if (emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_type_ff <= out_type_in;
         out_len_ff  <= out_len_in;
         out_ok_ff   <= out_ok_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_kind_ff;
   assign rsp_chan.data_byte    = out_data_ff;
   assign rsp_chan.frame_type   = out_type_ff;
   assign rsp_chan.frame_length = out_len_ff;
   assign rsp_chan.checksum_ok  = out_ok_ff;

   a_reset_phase: assert property (@(posedge clock)
      $past(reset) |-> (phase_ff == vlfr_pkg::PH_START && !out_valid_ff))
      else $error("parser not idle after reset");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vlfr_pkg::PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with nothing left");

   a_payload_no_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == vlfr_pkg::KIND_PAYLOAD) |-> !out_ok_ff)
      else $error("payload transaction carries checksum flag");

   a_end_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == vlfr_pkg::KIND_FRAME_END) |-> (out_data_ff == '0))
      else $error("frame end transaction carries data");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && out_valid_ff) |-> rsp_chan.ready)
      else $error("result overwritten before taken");

endmodule
